FILE: rtl/core/send_window_retransmit_scheduler_assert.svh
// Assertion macros for the send window scheduler.
`ifndef SEND_WINDOW_RETRANSMIT_SCHEDULER_ASSERT_SVH
`define SEND_WINDOW_RETRANSMIT_SCHEDULER_ASSERT_SVH

// Same-cycle implication.
`define SWRS_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication.
`define SWRS_ASSERT_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

FILE: rtl/core/swrs_pkg.sv
package swrs_pkg;

  localparam int WINDOW_SLOTS_DEF      = 32;
  localparam int ACK_HISTORY_BITS_DEF  = 32;
  localparam int MAX_MESSAGE_BYTES_DEF = 1024;
  localparam int OUT_LIMIT             = 32;

  localparam logic [31:0] RESEND_AFTER_RST = 32'd100;

  localparam logic [1:0] MODE_NEW     = 2'd0;
  localparam logic [1:0] MODE_TICK    = 2'd1;
  localparam logic [1:0] MODE_ACK     = 2'd2;
  localparam logic [1:0] MODE_DELIVER = 2'd3;

  localparam logic [2:0] KIND_ACCEPTED = 3'd0;
  localparam logic [2:0] KIND_REFUSED  = 3'd1;
  localparam logic [2:0] KIND_FRESH    = 3'd2;
  localparam logic [2:0] KIND_RESEND   = 3'd3;
  localparam logic [2:0] KIND_ACK_ONLY = 3'd4;
  localparam logic [2:0] KIND_NOTHING  = 3'd5;
  localparam logic [2:0] KIND_ACK_DONE = 3'd6;

endpackage

FILE: rtl/core/swrs_in_if.sv
interface swrs_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  mode;
  logic [11:0] length;
  logic [31:0] now;
  logic [15:0] ack_seq;
  logic [31:0] ack_bits;
  logic        peer_ack_valid;

  modport source (output valid, mode, length, now, ack_seq, ack_bits, peer_ack_valid,
                  input ready);
  modport sink (input valid, mode, length, now, ack_seq, ack_bits, peer_ack_valid,
                output ready);
endinterface

FILE: rtl/core/swrs_out_if.sv
interface swrs_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  kind;
  logic [15:0] seq;
  logic [4:0]  slot;
  logic [11:0] length_res;
  logic        with_ack;
  logic [5:0]  unacked_count;
  logic        last;

  modport source (output valid, kind, seq, slot, length_res, with_ack, unacked_count, last,
                  input ready);
  modport sink (input valid, kind, seq, slot, length_res, with_ack, unacked_count, last,
                output ready);
endinterface

FILE: rtl/core/swrs_ram.sv
module swrs_ram #(
  parameter int DEPTH = 32,
  parameter int WIDTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

FILE: rtl/core/send_window_retransmit_scheduler.sv
// Channel   Dir  Beat
// req       in   one command: new message, tick, peer ack or delivered notice
// res       out  one result; last marks the final result of a command
// cfg       in   resend_after write, any cycle the block is idle
//
// New message and delivered notice each give one result. Tick walks WINDOW_SLOTS slots from
// next_slot and stops early after OUT_LIMIT sends; its pace is set by the single read port of the
// slot memories. Ack: the ack slot is found first, then the acked and each marked sequence
// over ACK_HISTORY_BITS+1 is looked up in the slot memories, and unmarked ones are skipped.
// Reset is synchronous; no memory clearing pass. A stalled res holds the tick walk.
module send_window_retransmit_scheduler #(
  parameter int WINDOW_SLOTS      = swrs_pkg::WINDOW_SLOTS_DEF,
  parameter int ACK_HISTORY_BITS  = swrs_pkg::ACK_HISTORY_BITS_DEF,
  parameter int MAX_MESSAGE_BYTES = swrs_pkg::MAX_MESSAGE_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst,
  swrs_in_if.sink     req,
  swrs_out_if.source  res,
  input  logic        cfg_we,
  input  logic [31:0] cfg_wdata
);
  import swrs_pkg::*;

  localparam int IW = $clog2(WINDOW_SLOTS);
  localparam int CW = $clog2(WINDOW_SLOTS + 1);
  localparam int JW = $clog2(ACK_HISTORY_BITS + 1);
  localparam int RK = 16 + $clog2(WINDOW_SLOTS);
  localparam logic [39:0] RECIP = 40'(((64'd1 << RK) + 64'(WINDOW_SLOTS) - 64'd1)
                                      / 64'(WINDOW_SLOTS));
  localparam logic [IW-1:0] TOP_SLOT  = IW'(65535 % WINDOW_SLOTS);
  localparam logic [IW-1:0] LAST_SLOT = IW'(WINDOW_SLOTS - 1);

  typedef enum logic [9:0] {
    S_IDLE = 10'b0000000001,
    S_NEWM = 10'b0000000010,
    S_TRD  = 10'b0000000100,
    S_TCHK = 10'b0000001000,
    S_TEND = 10'b0000010000,
    S_AMOD = 10'b0000100000,
    S_ARD  = 10'b0001000000,
    S_ACHK = 10'b0010000000,
    S_AEND = 10'b0100000000,
    S_FIN  = 10'b1000000000
  } state_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [15:0] seq;
    logic [4:0]  slot;
    logic [11:0] len;
    logic        wa;
  } result_t;

  state_t state;
  logic [31:0] resend_after;
  logic [WINDOW_SLOTS-1:0] live, fresh;
  logic [15:0] next_seq;
  logic [IW-1:0] next_slot;
  logic ack_owed;
  logic [CW-1:0] live_cnt;
  logic [11:0] len_r;
  logic [31:0] now_r;
  logic peer_r;
  logic [15:0] ack_r, aseq, aquot;
  logic [ACK_HISTORY_BITS-1:0] abits;
  logic [IW-1:0] widx, wcnt, aidx;
  logic [5:0] nsent;
  logic [JW-1:0] jcnt;
  logic pend_valid;
  result_t pend;

  logic out_valid, out_last;
  result_t out_r;
  logic [CW-1:0] out_cnt;

  logic [IW-1:0] rd_addr, wr_addr;
  logic meta_we, time_we;
  logic [27:0] meta_rdata;
  logic [31:0] time_rdata, time_wdata;

  logic out_free, bad, due, fire, tick_last, ack_check, ack_done, ack_hit, push;
  logic [39:0] aq_prod;
  logic [15:0] arem;
  logic [IW+4:0] widx_x, nslot_x;

  assign out_free  = !out_valid || res.ready;
  assign bad       = (len_r == 12'd0) || (len_r > 12'(MAX_MESSAGE_BYTES)) || live[next_slot];
  assign due       = fresh[widx] || ((now_r - time_rdata) >= resend_after);
  assign fire      = state == S_TCHK && due && (!pend_valid || out_free);
  assign push      = (state == S_FIN && out_free) || (fire && pend_valid);
  assign tick_last = wcnt == LAST_SLOT;
  assign ack_check = (jcnt == '0) || abits[0];
  assign ack_done  = jcnt == JW'(ACK_HISTORY_BITS);
  assign ack_hit   = live[aidx] && (meta_rdata[27:12] == aseq);
  assign aq_prod   = {24'd0, req.ack_seq} * RECIP;
  assign arem      = ack_r - aquot * 16'(WINDOW_SLOTS);
  assign widx_x    = {5'd0, widx};
  assign nslot_x   = {5'd0, next_slot};

  assign meta_we    = state == S_NEWM && !bad;
  assign time_we    = meta_we || fire;
  assign wr_addr    = (state == S_NEWM) ? next_slot : widx;
  assign time_wdata = meta_we ? 32'd0 : now_r;
  assign rd_addr    = (state == S_ARD || state == S_ACHK) ? aidx : widx;

  swrs_ram #(.DEPTH(WINDOW_SLOTS), .WIDTH(28)) u_meta (
    .clk(clk), .we(meta_we), .waddr(wr_addr), .wdata({next_seq, len_r}),
    .raddr(rd_addr), .rdata(meta_rdata)
  );

  swrs_ram #(.DEPTH(WINDOW_SLOTS), .WIDTH(32)) u_time (
    .clk(clk), .we(time_we), .waddr(wr_addr), .wdata(time_wdata),
    .raddr(rd_addr), .rdata(time_rdata)
  );

  assign req.ready         = state == S_IDLE;
  assign res.valid         = out_valid;
  assign res.kind          = out_r.kind;
  assign res.seq           = out_r.seq;
  assign res.slot          = out_r.slot;
  assign res.length_res    = out_r.len;
  assign res.with_ack      = out_r.wa;
  assign res.unacked_count = 6'({{7{1'b0}}, out_cnt});
  assign res.last          = out_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      resend_after <= RESEND_AFTER_RST;
      live         <= '0;
      fresh        <= '0;
      next_seq     <= '0;
      next_slot    <= '0;
      ack_owed     <= 1'b0;
      live_cnt     <= '0;
      pend_valid   <= 1'b0;
      out_valid    <= 1'b0;
    end else begin
      if (cfg_we) begin
        resend_after <= cfg_wdata;
      end
      if (push) begin
        out_valid <= 1'b1;
      end else if (res.ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (req.valid) begin
            len_r      <= req.length;
            now_r      <= req.now;
            peer_r     <= req.peer_ack_valid;
            ack_r      <= req.ack_seq;
            aseq       <= req.ack_seq;
            aquot      <= 16'(aq_prod >> RK);
            abits      <= req.ack_bits[ACK_HISTORY_BITS-1:0];
            jcnt       <= '0;
            widx       <= next_slot;
            wcnt       <= '0;
            nsent      <= '0;
            unique case (req.mode)
              MODE_NEW:  state <= S_NEWM;
              MODE_TICK: state <= S_TRD;
              MODE_ACK:  state <= S_AMOD;
              default: begin
                ack_owed   <= 1'b1;
                pend       <= '{KIND_NOTHING, 16'd0, 5'd0, 12'd0, 1'b0};
                pend_valid <= 1'b1;
                state      <= S_FIN;
              end
            endcase
          end
        end
        S_NEWM: begin
          pend       <= '{(bad ? KIND_REFUSED : KIND_ACCEPTED), next_seq, nslot_x[4:0],
                          len_r, 1'b0};
          pend_valid <= 1'b1;
          if (!bad) begin
            live[next_slot]  <= 1'b1;
            fresh[next_slot] <= 1'b1;
            live_cnt         <= live_cnt + 1'b1;
            next_seq         <= next_seq + 16'd1;
            next_slot        <= (next_seq == 16'hFFFF || next_slot == LAST_SLOT) ? '0
                                : next_slot + 1'b1;
          end
          state <= S_FIN;
        end
        S_TRD: begin
          if (live[widx]) begin
            state <= S_TCHK;
          end else if (tick_last) begin
            state <= S_TEND;
          end else begin
            wcnt <= wcnt + 1'b1;
            widx <= (widx == LAST_SLOT) ? '0 : widx + 1'b1;
          end
        end
        S_TCHK: begin
          // hold while an earlier send still waits for the output register
          if (!due || fire) begin
            if (fire) begin
              pend        <= '{(fresh[widx] ? KIND_FRESH : KIND_RESEND), meta_rdata[27:12],
                               widx_x[4:0], meta_rdata[11:0], peer_r};
              pend_valid  <= 1'b1;
              fresh[widx] <= 1'b0;
              ack_owed    <= 1'b0;
              nsent       <= nsent + 6'd1;
            end
            if (tick_last || (fire && nsent == 6'(OUT_LIMIT - 1))) begin
              state <= S_TEND;
            end else begin
              wcnt  <= wcnt + 1'b1;
              widx  <= (widx == LAST_SLOT) ? '0 : widx + 1'b1;
              state <= S_TRD;
            end
          end
        end
        S_TEND: begin
          if (!pend_valid) begin
            pend_valid <= 1'b1;
            if (ack_owed) begin
              ack_owed <= 1'b0;
              pend     <= '{KIND_ACK_ONLY, 16'd0, 5'd0, 12'd0, 1'b1};
            end else begin
              pend <= '{KIND_NOTHING, 16'd0, 5'd0, 12'd0, 1'b0};
            end
          end
          state <= S_FIN;
        end
        S_AMOD: begin
          // slot of ack_seq from the quotient taken at accept
          aidx  <= arem[IW-1:0];
          state <= S_ARD;
        end
        S_ARD, S_ACHK: begin
          if (state == S_ARD && ack_check) begin
            state <= S_ACHK;
          end else begin
            if (state == S_ACHK && ack_hit) begin
              live[aidx] <= 1'b0;
              live_cnt   <= live_cnt - 1'b1;
            end
            if (ack_done) begin
              state <= S_AEND;
            end else begin
              if (jcnt != '0) begin
                abits <= abits >> 1;
              end
              jcnt  <= jcnt + 1'b1;
              aseq  <= aseq - 16'd1;
              aidx  <= (aseq == 16'd0) ? TOP_SLOT : ((aidx == '0) ? LAST_SLOT : aidx - 1'b1);
              state <= S_ARD;
            end
          end
        end
        S_AEND: begin
          pend       <= '{KIND_ACK_DONE, ack_r, 5'd0, 12'd0, 1'b0};
          pend_valid <= 1'b1;
          state      <= S_FIN;
        end
        S_FIN: begin
          if (out_free) begin
            pend_valid <= 1'b0;
            state      <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // push the held result; only the final beat of a command carries last
  always_ff @(posedge clk) begin
    if (push) begin
      out_r    <= pend;
      out_cnt  <= live_cnt;
      out_last <= state == S_FIN;
    end
  end
endmodule

FILE: rtl/core/swrs_checker.sv
`include "send_window_retransmit_scheduler_assert.svh"

module swrs_checker (
  input logic        clk,
  input logic        rst,
  input logic        req_valid,
  input logic        req_ready,
  input logic        res_valid,
  input logic        res_ready,
  input logic [2:0]  res_kind,
  input logic [15:0] res_seq,
  input logic        res_with_ack,
  input logic        res_last
);
  import swrs_pkg::*;

  `SWRS_ASSERT_NXT(a_res_hold, clk, rst, res_valid && !res_ready, res_valid)
  `SWRS_ASSERT_NXT(a_busy_after_req, clk, rst, req_valid && req_ready, !req_ready)
  `SWRS_ASSERT_NOW(a_busy_mid_burst, clk, rst, res_valid && !res_last, !req_ready)
  `SWRS_ASSERT_NOW(a_ack_only_form, clk, rst, res_valid && res_kind == KIND_ACK_ONLY,
                   res_with_ack && res_seq == 16'd0)
endmodule

bind send_window_retransmit_scheduler swrs_checker u_swrs_checker (
  .clk(clk), .rst(rst),
  .req_valid(req.valid), .req_ready(req.ready),
  .res_valid(res.valid), .res_ready(res.ready),
  .res_kind(res.kind), .res_seq(res.seq),
  .res_with_ack(res.with_ack), .res_last(res.last)
);
